// File: rtl/core/awbd_pkg.sv
// ----------------------------------------------------------------------------
// awbd_pkg
// Shared constants and types of the alpha-weighted box downscaler.
// ----------------------------------------------------------------------------
package awbd_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 8;
	localparam int CFG_DIM_W  = 11;
	localparam int CFG_SIDE_W = 9;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE = 2'd2;

	localparam logic [CFG_DIM_W-1:0]  RST_WIDTH    = 11'd64;
	localparam logic [CFG_DIM_W-1:0]  RST_HEIGHT   = 11'd64;
	localparam logic [CFG_SIDE_W-1:0] RST_MAX_SIDE = 9'd32;

	typedef struct packed {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [PIX_W-1:0]   alpha;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} pix_out_t;

endpackage

// File: rtl/core/alpha_weighted_box_downscale.sv
// ----------------------------------------------------------------------------
// alpha_weighted_box_downscale
// Area-average RGBA downscaler with alpha-weighted color.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order; the leading square of side
// S = min(width, height) is shrunk to T x T, T = min(S, max_side), and one
// result leaves per output pixel in raster order. For each accepted pixel
// the front reads, adds to and writes back the band-sum memory before it
// takes the next pixel. Each result is taken from the queue, divided in four
// radix-4 divider lanes and then loaded into the output register; a
// two-entry queue and the output register sit between front and back.
// After reset and after every register write a setup pass clears the band
// sums and divides S by T; full stays high.
// ----------------------------------------------------------------------------
module alpha_weighted_box_downscale #(
	parameter int MAX_SOURCE_SIDE = 1024,
	parameter int MAX_TARGET_SIDE = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [awbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [awbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_red,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_green,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_blue,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_alpha,
	output logic                              empty,
	input  logic                              pop,
	output logic [awbd_pkg::PIX_W-1:0]        out_red,
	output logic [awbd_pkg::PIX_W-1:0]        out_green,
	output logic [awbd_pkg::PIX_W-1:0]        out_blue,
	output logic [awbd_pkg::PIX_W-1:0]        out_alpha,
	output logic [awbd_pkg::COORD_W-1:0]      out_x,
	output logic [awbd_pkg::COORD_W-1:0]      out_y,
	output logic                              last_pixel
);
	import awbd_pkg::*;

	localparam int SW     = $clog2(MAX_SOURCE_SIDE + 1);
	localparam int CSUM_W = 2 * PIX_W + 2 * $clog2(MAX_SOURCE_SIDE);
	localparam int ASUM_W = PIX_W + 2 * $clog2(MAX_SOURCE_SIDE);
	localparam int AREA_W = 2 * SW;
	localparam int ITEM_W = 3 * CSUM_W + ASUM_W + AREA_W + 2 * COORD_W + 1;

	logic              q_push, q_full, q_pop, q_empty;
	logic [ITEM_W-1:0] q_in, q_out;
	pix_out_t          res;

	awbd_front #(
		.MSS(MAX_SOURCE_SIDE),
		.MTS(MAX_TARGET_SIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.pixel_alpha (pixel_alpha),
		.q_push      (q_push),
		.q_item      (q_in),
		.q_full      (q_full)
	);

	awbd_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(2)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	awbd_back #(
		.MSS(MAX_SOURCE_SIDE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_out),
		.q_pop   (q_pop),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	assign out_red    = res.red;
	assign out_green  = res.green;
	assign out_blue   = res.blue;
	assign out_alpha  = res.alpha;
	assign out_x      = res.x;
	assign out_y      = res.y;
	assign last_pixel = res.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("bin transfer into a full queue");

	a_last_on_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_pixel) |-> (out_x == out_y))
		else $error("last pixel off the diagonal");

	a_cfg_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_MAX_SIDE)) |=> full)
		else $error("register write did not start setup pass");

endmodule

// File: rtl/core/awbd_fifo.sv
// ----------------------------------------------------------------------------
// awbd_fifo
// Short register queue that decouples the accumulate front from the divider.
// ----------------------------------------------------------------------------
module awbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/awbd_front.sv
// ----------------------------------------------------------------------------
// awbd_front
// Configuration, position tracking, bin bounds and band-sum accumulation.
// ----------------------------------------------------------------------------
module awbd_front #(
	parameter int MSS = 1024,
	parameter int MTS = 256,
	localparam int SW     = $clog2(MSS + 1),
	localparam int CSUM_W = 2 * awbd_pkg::PIX_W + 2 * $clog2(MSS),
	localparam int ASUM_W = awbd_pkg::PIX_W + 2 * $clog2(MSS),
	localparam int AREA_W = 2 * SW,
	localparam int ITEM_W = 3 * CSUM_W + ASUM_W + AREA_W + 2 * awbd_pkg::COORD_W + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [awbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [awbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_red,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_green,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_blue,
	input  logic [awbd_pkg::PIX_W-1:0]        pixel_alpha,
	output logic                              q_push,
	output logic [ITEM_W-1:0]                 q_item,
	input  logic                              q_full
);
	import awbd_pkg::*;

	localparam int TW      = $clog2(MTS + 1);
	localparam int XW      = (MTS > 1) ? $clog2(MTS) : 1;
	localparam int SETUP_N = ((MTS > SW + 1) ? MTS : SW + 1) + 1;
	localparam int CW      = $clog2(SETUP_N + 1);

	localparam logic [1:0] ST_SETUP = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_ACC   = 2'd2;

	typedef struct packed {
		logic [CSUM_W-1:0] red;
		logic [CSUM_W-1:0] green;
		logic [CSUM_W-1:0] blue;
		logic [ASUM_W-1:0] alpha;
	} sums_t;

	typedef struct packed {
		logic [CSUM_W-1:0]  red;
		logic [CSUM_W-1:0]  green;
		logic [CSUM_W-1:0]  blue;
		logic [ASUM_W-1:0]  alpha;
		logic [AREA_W-1:0]  area;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} bin_t;

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [CFG_DIM_W-1:0]  width_q;
	logic [CFG_DIM_W-1:0]  height_q;
	logic [CFG_SIDE_W-1:0] max_side_q;

	logic [SW-1:0] w, h, s;
	logic [TW-1:0] lim, t;

	logic [SW-1:0] dnum_q;
	logic [TW-1:0] dr_q;
	logic [SW-1:0] q0_q;
	logic [TW:0]   dr_w;
	logic          dbit;

	logic [SW-1:0] r_q, c_q;
	logic [XW-1:0] oc_q, orow_q;
	logic [SW-1:0] cx0_q, cx1_q, ry0_q, ry1_q;
	logic [TW-1:0] crem_q, rrem_q;

	logic [TW:0]   csum_n, rsum_n;
	logic          ccarry, rcarry;
	logic [TW-1:0] crem_n, rrem_n;
	logic [SW-1:0] cx1_n, ry1_n;

	logic [PIX_W-1:0] red_q, green_q, blue_q, alpha_q;
	logic             in_sq_q;

	sums_t sums_mem [MTS];
	sums_t rd_q;
	sums_t acc;
	sums_t wr_data;
	logic  mem_we;
	logic [XW-1:0] mem_wa;

	logic col_close, row_close, emit, go;
	logic [SW-1:0] bin_w, bin_h;
	bin_t item;
	logic cfg_hit;

	assign cfg_hit = cfg_write &&
		(cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT || cfg_index == REG_MAX_SIDE);

	always_comb begin
		w = (width_q == '0) ? SW'(1) :
			((32'(width_q) > MSS) ? SW'(MSS) : SW'(width_q));
		h = (height_q == '0) ? SW'(1) :
			((32'(height_q) > MSS) ? SW'(MSS) : SW'(height_q));
		s = (w < h) ? w : h;
		lim = (max_side_q == '0) ? TW'(1) :
			((32'(max_side_q) > MTS) ? TW'(MTS) : TW'(max_side_q));
		t = (32'(s) < 32'(lim)) ? TW'(s) : lim;
	end

	// side / target, one quotient bit per setup cycle
	assign dr_w = {dr_q, dnum_q[SW-1]};
	assign dbit = (dr_w >= {1'b0, t});

	// next bin bound: add the quotient, carry the remainder
	always_comb begin
		csum_n = {1'b0, crem_q} + {1'b0, dr_q};
		ccarry = (csum_n >= {1'b0, t});
		crem_n = ccarry ? TW'(csum_n - {1'b0, t}) : csum_n[TW-1:0];
		cx1_n  = cx1_q + q0_q + SW'(ccarry);
		rsum_n = {1'b0, rrem_q} + {1'b0, dr_q};
		rcarry = (rsum_n >= {1'b0, t});
		rrem_n = rcarry ? TW'(rsum_n - {1'b0, t}) : rsum_n[TW-1:0];
		ry1_n  = ry1_q + q0_q + SW'(rcarry);
	end

	always_comb begin
		acc.red   = rd_q.red   + CSUM_W'(red_q   * alpha_q);
		acc.green = rd_q.green + CSUM_W'(green_q * alpha_q);
		acc.blue  = rd_q.blue  + CSUM_W'(blue_q  * alpha_q);
		acc.alpha = rd_q.alpha + ASUM_W'(alpha_q);
		col_close = (32'(c_q) + 1 == 32'(cx1_q));
		row_close = (32'(r_q) + 1 == 32'(ry1_q));
		emit      = (state_q == ST_ACC) && in_sq_q && col_close && row_close;
		go        = !emit || !q_full;
		bin_w     = cx1_q - cx0_q;
		bin_h     = ry1_q - ry0_q;
		item.red   = acc.red;
		item.green = acc.green;
		item.blue  = acc.blue;
		item.alpha = acc.alpha;
		item.area  = AREA_W'(bin_w) * AREA_W'(bin_h);
		item.x     = COORD_W'(oc_q);
		item.y     = COORD_W'(orow_q);
		item.last  = (32'(oc_q) + 1 == 32'(t)) && (32'(orow_q) + 1 == 32'(t));
	end

	assign q_push = emit && !q_full;
	assign q_item = item;
	assign full   = (state_q != ST_IDLE);

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = oc_q;
		wr_data = acc;
		unique case (state_q)
			ST_SETUP: begin
				mem_we  = (32'(cnt_q) < MTS);
				mem_wa  = XW'(cnt_q);
				wr_data = '0;
			end
			ST_ACC: begin
				mem_we  = go && in_sq_q;
				wr_data = emit ? '0 : acc;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[mem_wa] <= wr_data;
		end
		rd_q <= sums_mem[oc_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && push) begin
			red_q   <= pixel_red;
			green_q <= pixel_green;
			blue_q  <= pixel_blue;
			alpha_q <= pixel_alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SETUP;
			cnt_q      <= '0;
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			max_side_q <= RST_MAX_SIDE;
			dnum_q     <= '0;
			dr_q       <= '0;
			q0_q       <= '0;
			r_q        <= '0;
			c_q        <= '0;
			oc_q       <= '0;
			orow_q     <= '0;
			cx0_q      <= '0;
			cx1_q      <= '0;
			ry0_q      <= '0;
			ry1_q      <= '0;
			crem_q     <= '0;
			rrem_q     <= '0;
			in_sq_q    <= 1'b0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q    <= cfg_data[CFG_DIM_W-1:0];
				REG_HEIGHT: height_q   <= cfg_data[CFG_DIM_W-1:0];
				default:    max_side_q <= cfg_data[CFG_SIDE_W-1:0];
			endcase
			state_q <= ST_SETUP;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_SETUP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '0) begin
						dnum_q <= s;
						dr_q   <= '0;
						q0_q   <= '0;
					end else if (32'(cnt_q) <= SW) begin
						dr_q   <= dbit ? TW'(dr_w - {1'b0, t}) : dr_w[TW-1:0];
						q0_q   <= SW'({q0_q, dbit});
						dnum_q <= dnum_q << 1;
					end
					if (32'(cnt_q) == SETUP_N - 1) begin
						r_q     <= '0;
						c_q     <= '0;
						oc_q    <= '0;
						orow_q  <= '0;
						cx0_q   <= '0;
						cx1_q   <= q0_q;
						ry0_q   <= '0;
						ry1_q   <= q0_q;
						crem_q  <= dr_q;
						rrem_q  <= dr_q;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (push) begin
						in_sq_q <= (r_q < s) && (c_q < s);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (go) begin
						state_q <= ST_IDLE;
						if (32'(c_q) + 1 >= 32'(w)) begin
							// end of source row: rewind columns, maybe close a band
							c_q    <= '0;
							oc_q   <= '0;
							cx0_q  <= '0;
							cx1_q  <= q0_q;
							crem_q <= dr_q;
							if (32'(r_q) + 1 >= 32'(h)) begin
								r_q    <= '0;
								orow_q <= '0;
								ry0_q  <= '0;
								ry1_q  <= q0_q;
								rrem_q <= dr_q;
							end else begin
								r_q <= r_q + 1'b1;
								if (r_q < s && row_close && 32'(orow_q) + 1 < 32'(t)) begin
									orow_q <= orow_q + 1'b1;
									ry0_q  <= ry1_q;
									ry1_q  <= ry1_n;
									rrem_q <= rrem_n;
								end
							end
						end else begin
							c_q <= c_q + 1'b1;
							if (in_sq_q && col_close && 32'(oc_q) + 1 < 32'(t)) begin
								oc_q   <= oc_q + 1'b1;
								cx0_q  <= cx1_q;
								cx1_q  <= cx1_n;
								crem_q <= crem_n;
							end
						end
					end
				end
				default: begin
					state_q <= ST_SETUP;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/awbd_back.sv
// ----------------------------------------------------------------------------
// awbd_back
// Four radix-4 restoring divider lanes and the result output register.
// ----------------------------------------------------------------------------
module awbd_back #(
	parameter int MSS = 1024,
	localparam int SW     = $clog2(MSS + 1),
	localparam int CSUM_W = 2 * awbd_pkg::PIX_W + 2 * $clog2(MSS),
	localparam int ASUM_W = awbd_pkg::PIX_W + 2 * $clog2(MSS),
	localparam int AREA_W = 2 * SW,
	localparam int ITEM_W = 3 * CSUM_W + ASUM_W + AREA_W + 2 * awbd_pkg::COORD_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  logic [ITEM_W-1:0]  q_item,
	output logic               q_pop,
	output awbd_pkg::pix_out_t res,
	output logic               empty,
	input  logic               pop
);
	import awbd_pkg::*;

	localparam int NW  = CSUM_W + 2;
	localparam int DW  = ((ASUM_W > AREA_W) ? ASUM_W : AREA_W) + 1;
	localparam int DSW = DW + 7;
	localparam int RW  = (NW > DSW + 1) ? NW : DSW + 1;
	localparam int LANES = 4;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_DONE = 2'd2;

	typedef struct packed {
		logic [CSUM_W-1:0]  red;
		logic [CSUM_W-1:0]  green;
		logic [CSUM_W-1:0]  blue;
		logic [ASUM_W-1:0]  alpha;
		logic [AREA_W-1:0]  area;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} bin_t;

	bin_t item;
	logic [1:0] state_q;
	logic [1:0] step_q;
	logic [RW-1:0]    rem_q [LANES];
	logic [DSW-1:0]   dsh_q [LANES];
	logic [PIX_W-1:0] quo_q [LANES];
	logic [RW-1:0]    rem_n [LANES];
	logic [1:0]       qb_n  [LANES];
	logic [NW-1:0]    num   [LANES];
	logic [DW-1:0]    den   [LANES];
	logic [COORD_W-1:0] x_q, y_q;
	logic last_q, zero_q;
	pix_out_t out_q;
	logic out_valid_q;
	logic load_out;

	assign item  = q_item;
	assign q_pop = (state_q == B_IDLE) && !q_empty;

	always_comb begin
		num[0] = {item.red, 1'b0}   + NW'(item.alpha);
		num[1] = {item.green, 1'b0} + NW'(item.alpha);
		num[2] = {item.blue, 1'b0}  + NW'(item.alpha);
		num[3] = NW'({item.alpha, 1'b0}) + NW'(item.area);
		den[0] = DW'({item.alpha, 1'b0});
		den[1] = DW'({item.alpha, 1'b0});
		den[2] = DW'({item.alpha, 1'b0});
		den[3] = DW'({item.area, 1'b0});
	end

	// two quotient bits per lane per cycle
	always_comb begin
		logic [RW-1:0] rem_a;
		for (int i = 0; i < LANES; i++) begin
			rem_a = rem_q[i];
			qb_n[i] = 2'b00;
			if (rem_a >= RW'({dsh_q[i], 1'b0})) begin
				rem_a = rem_a - RW'({dsh_q[i], 1'b0});
				qb_n[i][1] = 1'b1;
			end
			if (rem_a >= RW'(dsh_q[i])) begin
				rem_a = rem_a - RW'(dsh_q[i]);
				qb_n[i][0] = 1'b1;
			end
			rem_n[i] = rem_a;
		end
	end

	assign load_out = (state_q == B_DONE) && (!out_valid_q || pop);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					for (int i = 0; i < LANES; i++) begin
						rem_q[i] <= RW'(num[i]);
						dsh_q[i] <= DSW'(den[i]) << 6;
						quo_q[i] <= '0;
					end
					x_q    <= item.x;
					y_q    <= item.y;
					last_q <= item.last;
					zero_q <= (item.alpha == '0);
				end
			end
			B_DIV: begin
				for (int i = 0; i < LANES; i++) begin
					rem_q[i] <= rem_n[i];
					dsh_q[i] <= dsh_q[i] >> 2;
					quo_q[i] <= {quo_q[i][PIX_W-3:0], qb_n[i]};
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			// no alpha in the bin: color reads as black
			out_q.red   <= zero_q ? '0 : quo_q[0];
			out_q.green <= zero_q ? '0 : quo_q[1];
			out_q.blue  <= zero_q ? '0 : quo_q[2];
			out_q.alpha <= quo_q[3];
			out_q.x     <= x_q;
			out_q.y     <= y_q;
			out_q.last  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_DIV;
						step_q  <= '0;
					end
				end
				B_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign res   = out_q;
	assign empty = !out_valid_q;

endmodule
